// File: sv/mipmap_box_downsample_2x2_macros.svh
// Assertion macros used by the checker file
`ifndef MIPMAP_BOX_DOWNSAMPLE_2X2_MACROS_SVH
`define MIPMAP_BOX_DOWNSAMPLE_2X2_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define MBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define MBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mbd_pkg.sv
package mbd_pkg;

    localparam int CFG_W      = 9;
    localparam int ROW_W      = 8;
    localparam int CH_W       = 8;
    localparam int PAIR_W     = CH_W + 1;
    localparam int NUM_CH     = 4;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int MAX_HEIGHT = 256;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 9'd64;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 9'd64;

    // Register index, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic [NUM_CH-1:0][CH_W-1:0]   pixel_t;
    typedef logic [NUM_CH-1:0][PAIR_W-1:0] pair_t;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic             restart;
    } cfg_ctrl_t;

    typedef struct packed {
        logic emit;
        logic row_end;
        logic frame_end;
    } tag_t;

endpackage

// File: sv/mbd_apb_regs.sv
module mbd_apb_regs #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mbd_pkg::ADDR_W-1:0] paddr,
    input  logic [mbd_pkg::DATA_W-1:0] pwdata,
    output logic [mbd_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output mbd_pkg::cfg_ctrl_t         cfg
);
    import mbd_pkg::*;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] width_next;
    logic [CFG_W-1:0] height_reg;
    logic [CFG_W-1:0] height_next;
    logic             wr_en;

    // Round down to even, then saturate to 2..hi
    function automatic logic [CFG_W-1:0] clamp_even(input logic [CFG_W-1:0] v, input int hi);
        logic [CFG_W-1:0] r;
        r = v & ~(CFG_W'(1));
        if (r < CFG_W'(2)) r = CFG_W'(2);
        if (32'(r) > hi) r = CFG_W'(hi & ~1);
        return r;
    endfunction

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_WIDTH:  width_next  = pwdata[CFG_W-1:0];
                REG_HEIGHT: height_next = pwdata[CFG_W-1:0];
                default:    width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_WIDTH:  prdata = DATA_W'(width_reg);
            REG_HEIGHT: prdata = DATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.width   = clamp_even(width_reg, MAX_WIDTH);
    assign cfg.height  = clamp_even(height_reg, MAX_HEIGHT);
    // Any register write starts a new frame
    assign cfg.restart = wr_en;

endmodule

// File: sv/mbd_scan.sv
module mbd_scan #(
    parameter int MAX_WIDTH  = 256,
    parameter int LINE_DEPTH = 128,
    parameter int SLOT_W     = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mbd_pkg::cfg_ctrl_t   cfg,
    input  logic                 in_fire,
    input  mbd_pkg::pixel_t      pixel,
    output logic                 ram_we,
    output logic                 ram_re,
    output logic [SLOT_W-1:0]    ram_addr,
    output mbd_pkg::pair_t       pair,
    output mbd_pkg::tag_t        tag
);
    import mbd_pkg::*;

    localparam int WMAX  = (MAX_WIDTH > 510) ? 510 : (MAX_WIDTH & ~1);
    localparam int COL_W = (WMAX > 2) ? $clog2(WMAX) : 1;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    pixel_t           left_reg;
    pixel_t           left_next;
    logic [COL_W-1:0] col_half;
    logic             last_col;
    logic             last_row;
    logic             odd_col;
    logic             odd_row;

    assign last_col = (CFG_W'(col_reg) + CFG_W'(1)) >= cfg.width;
    assign last_row = (CFG_W'(row_reg) + CFG_W'(1)) >= cfg.height;
    assign odd_col  = col_reg[0];
    assign odd_row  = row_reg[0];
    assign col_half = col_reg >> 1;
    assign ram_addr = SLOT_W'(32'(col_half) & 32'(LINE_DEPTH - 1));

    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            pair[i] = PAIR_W'(left_reg[i]) + PAIR_W'(pixel[i]);
        end
    end

    // Even rows store pair sums, odd rows fetch them for the block result
    assign ram_we        = in_fire && odd_col && !odd_row;
    assign ram_re        = in_fire && odd_col && odd_row;
    assign tag.emit      = odd_col && odd_row;
    assign tag.row_end   = last_col;
    assign tag.frame_end = last_col && last_row;

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        if (cfg.restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_fire)
        begin
            if (!odd_col)
            begin
                left_next = pixel;
            end
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            left_reg <= left_next;
        end
    end

endmodule

// File: sv/mbd_line_ram.sv
module mbd_line_ram #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7,
    parameter int WORD_W = 36
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WORD_W-1:0] wdata,
    output logic [WORD_W-1:0] rdata
);
    logic [WORD_W-1:0] line_mem_reg [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    // Read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            line_mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= line_mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/mipmap_box_downsample_2x2.sv
// 2x2 box downsample of an RGBA8 raster stream, one pixel accepted per cycle while
// in_ready is high. A block result passes from the closing pixel's transfer through
// stage 1 into the output registers; throughput, set by the single line store port
// (a write on even rows, a read on odd rows), is one pixel per cycle unless stalled.
// Reset clears counters, left pixel and valid flags; the line store is not cleared.
module mipmap_box_downsample_2x2 #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mbd_pkg::ADDR_W-1:0] paddr,
    input  logic [mbd_pkg::DATA_W-1:0] pwdata,
    output logic [mbd_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [mbd_pkg::CH_W-1:0]   red_in,
    input  logic [mbd_pkg::CH_W-1:0]   green_in,
    input  logic [mbd_pkg::CH_W-1:0]   blue_in,
    input  logic [mbd_pkg::CH_W-1:0]   alpha_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [mbd_pkg::CH_W-1:0]   red_out,
    output logic [mbd_pkg::CH_W-1:0]   green_out,
    output logic [mbd_pkg::CH_W-1:0]   blue_out,
    output logic [mbd_pkg::CH_W-1:0]   alpha_out,
    output logic                       row_end,
    output logic                       frame_end
);
    import mbd_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int WORD_W     = NUM_CH * PAIR_W;

    cfg_ctrl_t             cfg;
    pixel_t                pixel;
    pair_t                 pair;
    tag_t                  tag;
    logic                  ram_we;
    logic                  ram_re;
    logic [SLOT_W-1:0]     ram_addr;
    logic [WORD_W-1:0]     ram_rdata;
    pair_t                 above;
    pixel_t                avg;
    logic                  in_fire;
    logic                  s1_move;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    pair_t                 s1_pair_reg;
    pair_t                 s1_pair_next;
    logic                  s1_row_end_reg;
    logic                  s1_row_end_next;
    logic                  s1_frame_end_reg;
    logic                  s1_frame_end_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    pixel_t                out_pix_reg;
    pixel_t                out_pix_next;
    logic                  out_row_end_reg;
    logic                  out_row_end_next;
    logic                  out_frame_end_reg;
    logic                  out_frame_end_next;

    mbd_apb_regs #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign pixel = {alpha_in, blue_in, green_in, red_in};

    mbd_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .LINE_DEPTH (LINE_DEPTH),
        .SLOT_W     (SLOT_W)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_fire  (in_fire),
        .pixel    (pixel),
        .ram_we   (ram_we),
        .ram_re   (ram_re),
        .ram_addr (ram_addr),
        .pair     (pair),
        .tag      (tag)
    );

    mbd_line_ram #(
        .DEPTH  (LINE_DEPTH),
        .ADDR_W (SLOT_W),
        .WORD_W (WORD_W)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (pair),
        .rdata (ram_rdata)
    );

    // Stage 1 waits on the line read; it moves on whenever the output slot frees
    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_fire  = in_valid && in_ready;

    assign above = ram_rdata;

    always_comb
    begin
        logic [PAIR_W:0] sum;
        for (int i = 0; i < NUM_CH; i++)
        begin
            sum    = {1'b0, above[i]} + {1'b0, s1_pair_reg[i]};
            avg[i] = sum[PAIR_W:2];
        end
    end

    always_comb
    begin
        s1_valid_next      = s1_valid_reg;
        s1_pair_next       = s1_pair_reg;
        s1_row_end_next    = s1_row_end_reg;
        s1_frame_end_next  = s1_frame_end_reg;
        out_valid_next     = out_valid_reg;
        out_pix_next       = out_pix_reg;
        out_row_end_next   = out_row_end_reg;
        out_frame_end_next = out_frame_end_reg;

        if (in_fire)
        begin
            s1_valid_next     = tag.emit;
            s1_pair_next      = pair;
            s1_row_end_next   = tag.row_end;
            s1_frame_end_next = tag.frame_end;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        if (s1_move)
        begin
            out_valid_next     = 1'b1;
            out_pix_next       = avg;
            out_row_end_next   = s1_row_end_reg;
            out_frame_end_next = s1_frame_end_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pair_reg       <= s1_pair_next;
        s1_row_end_reg    <= s1_row_end_next;
        s1_frame_end_reg  <= s1_frame_end_next;
        out_pix_reg       <= out_pix_next;
        out_row_end_reg   <= out_row_end_next;
        out_frame_end_reg <= out_frame_end_next;
    end

    assign out_valid = out_valid_reg;
    assign red_out   = out_pix_reg[0];
    assign green_out = out_pix_reg[1];
    assign blue_out  = out_pix_reg[2];
    assign alpha_out = out_pix_reg[3];
    assign row_end   = out_row_end_reg;
    assign frame_end = out_frame_end_reg;

endmodule

// File: sv/mbd_checker.sv
`include "mipmap_box_downsample_2x2_macros.svh"

module mbd_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [mbd_pkg::CH_W-1:0] red_out,
    input logic [mbd_pkg::CH_W-1:0] green_out,
    input logic [mbd_pkg::CH_W-1:0] blue_out,
    input logic [mbd_pkg::CH_W-1:0] alpha_out,
    input logic                     row_end,
    input logic                     frame_end
);

    // A stalled result holds until its transfer
    `MBD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({red_out, green_out, blue_out, alpha_out, row_end, frame_end}), "stalled result changed")

    // The last pixel of a frame also ends its row
    `MBD_ASSERT_IMPLY(a_frame_row, clk, rst_n, out_valid && frame_end, row_end, "frame_end without row_end")

    // A fresh result follows an input transfer that passed through stage 1
    `MBD_ASSERT_IMPLY(a_rose_src, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "result without input transfer")

endmodule

bind mipmap_box_downsample_2x2 mbd_checker u_mbd_checker (.*);
